[rtl/prrs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prrs_pkg
// Shared types, codes and defaults for the priority round-robin scheduler.
// ----------------------------------------------------------------------------
package prrs_pkg;

    localparam int NUM_LEVELS_DEF = 8;
    localparam int MAX_PROCS_DEF  = 64;

    // Fixed field widths of the transfer payloads
    localparam int CMD_W    = 1;
    localparam int PID_W    = 6;
    localparam int PRIO_W   = 3;
    localparam int STATUS_W = 2;

    // Level index width wide enough for the largest supported level count
    localparam int LVL_MAX_W = 5;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RESCHED = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PID_W-1:0]  process_id;
        logic [PRIO_W-1:0] priority_req;
        logic              ready_req;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PID_W-1:0]    running_id;
        logic                running_valid;
    } out_item_t;

    typedef struct packed {
        logic                 found;
        logic [LVL_MAX_W-1:0] level;
    } pick_t;

endpackage : prrs_pkg
`default_nettype wire

[rtl/prrs_pick_level.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prrs_pick_level
// Priority encoder: highest non-empty priority level.
// ----------------------------------------------------------------------------
module prrs_pick_level #(
    parameter int NUM_LEVELS = prrs_pkg::NUM_LEVELS_DEF
) (
    input  wire logic [NUM_LEVELS-1:0] nonempty,
    output prrs_pkg::pick_t            pick
);
    import prrs_pkg::*;

    always_comb begin
        pick.found = 1'b0;
        pick.level = '0;
        // ascending scan, the last set bit wins
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (nonempty[i]) begin
                pick.found = 1'b1;
                pick.level = LVL_MAX_W'(i);
            end
        end
    end

endmodule : prrs_pick_level
`default_nettype wire

[rtl/priority_round_robin_scheduler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler
// Multilevel priority FIFO scheduler; queue links kept in a synchronous RAM.
// ----------------------------------------------------------------------------
// Enqueue: result valid the cycle after the input transfer; one item per cycle
// while results are taken. Reschedule: result loaded in S_POP, or in S_LINK
// when the popped head has a successor (link RAM read of the new head).
// A reschedule may be taken while a result waits; an enqueue needs the
// result register free. Reset clears queues, flags and the running process.
// ----------------------------------------------------------------------------
module priority_round_robin_scheduler #(
    parameter int NUM_LEVELS = prrs_pkg::NUM_LEVELS_DEF,
    parameter int MAX_PROCS  = prrs_pkg::MAX_PROCS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire prrs_pkg::in_item_t  s_payload,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output prrs_pkg::out_item_t      m_payload
);
    import prrs_pkg::*;

    localparam int LW = $clog2(NUM_LEVELS);
    localparam int PW = $clog2(MAX_PROCS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_LINK = 2'd2;

    logic [1:0]            state_reg;
    logic [NUM_LEVELS-1:0] nonempty_reg;
    logic [MAX_PROCS-1:0]  queued_reg;
    logic [PW-1:0]         head_reg [NUM_LEVELS];
    logic [PW-1:0]         tail_reg [NUM_LEVELS];
    logic [PW-1:0]         cur_reg;
    logic                  cur_valid_reg;
    logic [LW-1:0]         pop_lvl_reg;
    logic                  m_valid_reg;
    out_item_t             m_payload_reg;

    logic [PW-1:0]         link_mem [MAX_PROCS];
    logic [PW-1:0]         link_rdata_reg;

    pick_t                 pick;
    logic [LW-1:0]         pop_lvl;
    logic                  accept;
    logic                  out_free;
    logic                  is_resched;
    logic [LW-1:0]         lvl_in;
    logic                  lvl_ok;
    logic                  pid_ok;
    logic [PW-1:0]         enq_pid;
    logic                  enq_ok;
    logic                  enq_do;
    logic [LW-1:0]         tail_idx;
    logic [PW-1:0]         tail_rd;
    logic [PW-1:0]         head_rd;
    logic                  link_we;
    logic                  link_re;
    logic                  out_load;
    out_item_t             m_payload_next;

    prrs_pick_level #(
        .NUM_LEVELS(NUM_LEVELS)
    ) u_pick (
        .nonempty(nonempty_reg),
        .pick    (pick)
    );

    assign pop_lvl    = LW'(pick.level);
    assign out_free   = !m_valid_reg || m_ready;
    assign is_resched = (s_payload.command == CMD_RESCHED);
    assign s_ready    = (state_reg == S_IDLE) && (out_free || is_resched);
    assign accept     = s_valid && s_ready;

    assign lvl_in  = LW'(s_payload.priority_req);
    assign lvl_ok  = 32'(s_payload.priority_req) < NUM_LEVELS;
    assign pid_ok  = is_resched || (32'(s_payload.process_id) < MAX_PROCS);
    assign enq_pid = is_resched ? cur_reg : PW'(s_payload.process_id);

    always_comb begin
        enq_ok = 1'b0;
        if (s_payload.ready_req && lvl_ok && pid_ok) begin
            enq_ok = !queued_reg[enq_pid];
        end
    end

    // reschedule re-enqueues the running process only when one is running
    assign enq_do = accept && enq_ok && (!is_resched || cur_valid_reg);

    // one tail read port: requested level on transfer, picked level on pop
    assign tail_idx = (state_reg == S_POP) ? pop_lvl : lvl_in;
    assign tail_rd  = tail_reg[tail_idx];
    assign head_rd  = head_reg[pop_lvl];

    assign link_we = enq_do && nonempty_reg[lvl_in];
    assign link_re = (state_reg == S_POP) && out_free && pick.found && (head_rd != tail_rd);

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[tail_rd] <= enq_pid;
        end
        if (link_re) begin
            link_rdata_reg <= link_mem[head_rd];
        end
    end

    always_comb begin
        out_load                     = 1'b0;
        m_payload_next.status        = ST_DONE;
        m_payload_next.running_id    = PID_W'(cur_reg);
        m_payload_next.running_valid = cur_valid_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && !is_resched) begin
                    out_load              = 1'b1;
                    m_payload_next.status = enq_ok ? ST_DONE : ST_REFUSED;
                end
            end
            S_POP: begin
                if (out_free) begin
                    if (!pick.found) begin
                        out_load                     = 1'b1;
                        m_payload_next.status        = ST_NONE;
                        m_payload_next.running_id    = '0;
                        m_payload_next.running_valid = 1'b0;
                    end else if (head_rd == tail_rd) begin
                        out_load                     = 1'b1;
                        m_payload_next.running_id    = PID_W'(head_rd);
                        m_payload_next.running_valid = 1'b1;
                    end
                end
            end
            S_LINK: begin
                out_load = 1'b1;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            nonempty_reg  <= '0;
            queued_reg    <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            pop_lvl_reg   <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (enq_do) begin
                        queued_reg[enq_pid] <= 1'b1;
                        tail_reg[lvl_in]    <= enq_pid;
                        if (!nonempty_reg[lvl_in]) begin
                            head_reg[lvl_in]     <= enq_pid;
                            nonempty_reg[lvl_in] <= 1'b1;
                        end
                    end
                    if (accept && is_resched) begin
                        state_reg <= S_POP;
                    end
                end
                S_POP: begin
                    if (out_free) begin
                        if (!pick.found) begin
                            cur_reg       <= '0;
                            cur_valid_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                        end else begin
                            queued_reg[head_rd] <= 1'b0;
                            cur_reg             <= head_rd;
                            cur_valid_reg       <= 1'b1;
                            if (head_rd == tail_rd) begin
                                // last entry leaves the level
                                nonempty_reg[pop_lvl] <= 1'b0;
                                head_reg[pop_lvl]     <= '0;
                                tail_reg[pop_lvl]     <= '0;
                                state_reg             <= S_IDLE;
                            end else begin
                                pop_lvl_reg <= pop_lvl;
                                state_reg   <= S_LINK;
                            end
                        end
                    end
                end
                S_LINK: begin
                    head_reg[pop_lvl_reg] <= link_rdata_reg;
                    state_reg             <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // no new transfer while a reschedule is in flight
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("input accepted while a reschedule is in flight");

    // the link stage always finds the result register empty
    a_link_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LINK) |-> !m_valid_reg)
        else $error("result register busy during head update");

    // nothing runnable leaves no running process
    a_none_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_payload_reg.status == ST_NONE)) |->
            (!m_payload_reg.running_valid && !cur_valid_reg))
        else $error("running process reported with nothing runnable");

endmodule : priority_round_robin_scheduler
`default_nettype wire
